### hw/rtl/rss_pkg.sv
// Shared types, codes and helper functions of the row store with select scan.
// Used by the top level, the hash unit and the register file; depends on nothing else.
package rss_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int ROW_BITS_DEF = 64;

  localparam int DATA_W       = 64;
  localparam int HASH_W       = 32;
  localparam int ID_W         = 7;
  localparam int PADDR_W      = 5;
  localparam int APB_W        = 32;
  localparam int RESULT_LIMIT = 64;
  localparam int HASH_SPAN    = 4;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_GET    = 3'd2,
    OP_DELETE = 3'd3,
    OP_SELEQ  = 3'd4,
    OP_SELALL = 3'd5
  } opcode_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOROW = 2'd2;

  localparam logic [2:0] REG_ROW_BYTES    = 3'd0;
  localparam logic [2:0] REG_CAPACITY     = 3'd1;
  localparam logic [2:0] REG_KEY_OFFSET   = 3'd2;
  localparam logic [2:0] REG_KEY_BYTES    = 3'd3;
  localparam logic [2:0] REG_INDEX_ENABLE = 3'd4;
  localparam logic [2:0] REG_INDEX_OFFSET = 3'd5;
  localparam logic [2:0] REG_MAX_MATCHES  = 3'd6;

  typedef struct packed {
    logic [3:0] row_bytes;
    logic [6:0] capacity;
    logic [2:0] key_offset;
    logic [3:0] key_bytes;
    logic       index_enable;
    logic [2:0] index_offset;
    logic [6:0] max_matches;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hash_sts_t;

  // Limits a byte count to the range one to top.
  function automatic logic [3:0] clamp_bytes(logic [3:0] n, logic [3:0] top);
    logic [3:0] r;
    r = n;
    if (n == 4'd0) r = 4'd1;
    else if (n > top) r = top;
    return r;
  endfunction

  // Mask that keeps the low n bytes of a 64-bit word.
  function automatic logic [DATA_W-1:0] byte_mask(logic [3:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int k = 0; k < DATA_W / 8; k++) begin
      if (4'(k) < n) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### hw/rtl/row_store_with_select_scan.sv
// Top level of the row store: sequencer, row and hash memories, hash unit, registers.
// Depends on rss_pkg, rss_ram, rss_hash and rss_cfg.
//
// Usage. A request enters on the input channel (in_valid_i / in_ready_o) with
// an opcode, a 1-based row id, row data and a select value. Each request
// yields one or more results on the output channel (out_valid_o /
// out_ready_i); the final result of a request carries last_o. Requests are
// served one at a time: in_ready_o is high only while the sequencer is idle,
// but a finished result may still be waiting in the output register then.
// Order of events: failed, trivial and empty-select requests go straight to
// the reply; get and delete with a row move first read the memory; insert
// and update run four hash steps through the single 32 by 32 multiplier,
// then the memory write. Selects read one row per cycle from the row memory
// while the scan is not held; a match found while the previous one still
// waits at the output holds the scan until the receiver takes it. One match
// is always held back so that the final one can be flagged with last_o.
// Reset clears the row count and all handshake state and sets the
// configuration registers to their defaults; the memories are not cleared,
// since only rows below the count are ever read. A receiver that stalls
// simply holds the result in the output register and the sequencer waits;
// nothing is dropped.
module row_store_with_select_scan import rss_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [ID_W-1:0]    row_id_i,
  input  logic [DATA_W-1:0]  row_data_i,
  input  logic [DATA_W-1:0]  key_value_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [ID_W-1:0]    result_row_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic [HASH_W-1:0]  read_hash_o,
  output logic [ID_W-1:0]    rows_held_o,
  output logic               last_o
);

  localparam int ADDR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TOP_BYTES = ROW_BITS / 8;
  localparam int CAP_TOP   = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_GETRD,
    S_DELRD,
    S_SCAN,
    S_FLUSH,
    S_REPLY
  } state_e;

  // Maps a row index held in a row-id-wide value onto a memory address.
  function automatic logic [ADDR_W-1:0] to_addr(logic [ID_W-1:0] v);
    logic [ADDR_W+ID_W-1:0] w;
    w = {{ADDR_W{1'b0}}, v};
    return w[ADDR_W-1:0];
  endfunction

  cfg_t              cfg;
  hash_sts_t         hash_sts;
  logic [HASH_W-1:0] hash_val;

  state_e            state_q, state_d;
  logic [ID_W-1:0]   count_q, count_d;
  opcode_e           op_q, op_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [ROW_BITS-1:0] wr_row_q, wr_row_d;

  logic [1:0]        rep_status_q, rep_status_d;
  logic [ID_W-1:0]   rep_id_q, rep_id_d;
  logic [DATA_W-1:0] rep_data_q, rep_data_d;
  logic [HASH_W-1:0] rep_hash_q, rep_hash_d;

  logic [ID_W-1:0]   scan_idx_q, scan_idx_d;
  logic              cmp_v_q, cmp_v_d;
  logic [ID_W-1:0]   cmp_id_q, cmp_id_d;
  logic [ID_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic              pend_v_q, pend_v_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [ID_W-1:0]   out_row_q;
  logic [DATA_W-1:0] out_data_q;
  logic [HASH_W-1:0] out_hash_q;
  logic [ID_W-1:0]   out_held_q;
  logic              out_last_q;

  logic              out_load;
  logic [1:0]        emit_status;
  logic [ID_W-1:0]   emit_row;
  logic [DATA_W-1:0] emit_data;
  logic [HASH_W-1:0] emit_hash;
  logic              emit_last;
  logic              out_busy;

  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic                row_we;
  logic [ROW_BITS-1:0] row_wdata;
  logic [ROW_BITS-1:0] row_rdata;
  logic [HASH_W-1:0]   hash_wdata;
  logic [HASH_W-1:0]   hash_rdata;
  logic                hash_start;

  logic [DATA_W-1:0] row_mask;
  logic [DATA_W-1:0] key_mask;
  logic [DATA_W-1:0] in_masked;
  logic [DATA_W-1:0] in_hash_sh;
  logic [DATA_W-1:0] rd_row;
  logic [DATA_W-1:0] rd_key_sh;
  logic              key_hit;
  logic [ID_W-1:0]   cap_eff;
  logic [ID_W-1:0]   limit;
  logic              in_id_ok;
  logic              scan_hit;
  logic              lim_now;
  logic              issue;

  rss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective register values: capacity limited to the memory depth, the
  // match limit to the result limit, byte counts to the stored row width.
  assign cap_eff  = (cfg.capacity > ID_W'(CAP_TOP)) ? ID_W'(CAP_TOP) : cfg.capacity;
  assign limit    = (cfg.max_matches > ID_W'(RESULT_LIMIT)) ?
                    ID_W'(RESULT_LIMIT) : cfg.max_matches;
  assign row_mask = byte_mask(clamp_bytes(cfg.row_bytes, 4'(TOP_BYTES)));
  assign key_mask = byte_mask(clamp_bytes(cfg.key_bytes, 4'(TOP_BYTES)));

  // Incoming row data is masked before it is stored and hashed. The hash
  // window is the four bytes starting at the index offset; bytes past the
  // end of the word shift in as zero.
  assign in_masked  = row_data_i & row_mask;
  assign in_hash_sh = in_masked >> {cfg.index_offset, 3'b000};
  assign in_id_ok   = (row_id_i != '0) && (row_id_i <= count_q);

  // Key compare on the row word coming out of the memory.
  assign rd_row    = DATA_W'(row_rdata) & row_mask;
  assign rd_key_sh = rd_row >> {cfg.key_offset, 3'b000};
  assign key_hit   = ((rd_key_sh ^ key_q) & key_mask) == '0;

  rss_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .enable_i (cfg.index_enable),
    .window_i (in_hash_sh[HASH_W-1:0]),
    .sts_o    (hash_sts),
    .hash_o   (hash_val)
  );

  // Row and hash memories share their addresses; reads and writes are never
  // in flight for the same entry at once, as one request is served at a time.
  rss_ram #(.WIDTH(ROW_BITS), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (wr_addr_q),
    .wdata_i (row_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (row_rdata)
  );

  rss_ram #(.WIDTH(HASH_W), .DEPTH(MAX_ROWS)) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (wr_addr_q),
    .wdata_i (hash_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (hash_rdata)
  );

  // The delete move copies the last row and its hash; every other write
  // takes the staged row and the fresh hash.
  assign row_wdata  = (state_q == S_DELRD) ? row_rdata  : wr_row_q;
  assign hash_wdata = (state_q == S_DELRD) ? hash_rdata : hash_val;

  assign out_busy = out_valid_q && !out_ready_i;

  // A scan candidate counts as a hit for select-all, or on a key match.
  assign scan_hit = cmp_v_q && ((op_q == OP_SELALL) || key_hit);
  assign lim_now  = scan_hit && ((hit_cnt_q + ID_W'(1)) == limit);
  assign issue    = !lim_now && (scan_idx_q < count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    rid_d        = rid_q;
    key_d        = key_q;
    wr_addr_d    = wr_addr_q;
    wr_row_d     = wr_row_q;
    rep_status_d = rep_status_q;
    rep_id_d     = rep_id_q;
    rep_data_d   = rep_data_q;
    rep_hash_d   = rep_hash_q;
    scan_idx_d   = scan_idx_q;
    cmp_v_d      = cmp_v_q;
    cmp_id_d     = cmp_id_q;
    hit_cnt_d    = hit_cnt_q;
    pend_v_d     = pend_v_q;
    pend_id_d    = pend_id_q;

    in_ready_o  = (state_q == S_IDLE);
    hash_start  = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = to_addr(scan_idx_q);
    row_we      = 1'b0;
    out_load    = 1'b0;
    emit_status = ST_OK;
    emit_row    = '0;
    emit_data   = '0;
    emit_hash   = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = opcode_e'(opcode_i);
          rid_d        = row_id_i;
          key_d        = key_value_i;
          rep_status_d = ST_OK;
          rep_id_d     = '0;
          rep_data_d   = '0;
          rep_hash_d   = '0;
          state_d      = S_REPLY;
          unique case (opcode_e'(opcode_i))
            OP_INSERT: begin
              if (count_q >= cap_eff) begin
                rep_status_d = ST_FULL;
              end else begin
                wr_addr_d  = to_addr(count_q);
                wr_row_d   = in_masked[ROW_BITS-1:0];
                hash_start = 1'b1;
                state_d    = S_HASH;
              end
            end
            OP_UPDATE: begin
              if (!in_id_ok) begin
                rep_status_d = ST_NOROW;
              end else begin
                wr_addr_d  = to_addr(row_id_i - ID_W'(1));
                wr_row_d   = in_masked[ROW_BITS-1:0];
                hash_start = 1'b1;
                state_d    = S_HASH;
              end
            end
            OP_GET: begin
              if (!in_id_ok) begin
                rep_status_d = ST_NOROW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = to_addr(row_id_i - ID_W'(1));
                state_d   = S_GETRD;
              end
            end
            OP_DELETE: begin
              if (!in_id_ok) begin
                rep_status_d = ST_NOROW;
              end else if (row_id_i < count_q) begin
                mem_re    = 1'b1;
                mem_raddr = to_addr(count_q - ID_W'(1));
                wr_addr_d = to_addr(row_id_i - ID_W'(1));
                state_d   = S_DELRD;
              end else begin
                count_d  = count_q - ID_W'(1);
                rep_id_d = row_id_i;
              end
            end
            OP_SELEQ, OP_SELALL: begin
              scan_idx_d = '0;
              cmp_v_d    = 1'b0;
              hit_cnt_d  = '0;
              pend_v_d   = 1'b0;
              if ((count_q == '0) || (limit == '0)) begin
                state_d = S_FLUSH;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_HASH: begin
        if (hash_sts.done) begin
          row_we = 1'b1;
          if (op_q == OP_INSERT) begin
            count_d  = count_q + ID_W'(1);
            rep_id_d = count_q + ID_W'(1);
          end else begin
            rep_id_d = rid_q;
          end
          state_d = S_REPLY;
        end
      end

      S_GETRD: begin
        rep_id_d   = rid_q;
        rep_data_d = rd_row;
        rep_hash_d = hash_rdata;
        state_d    = S_REPLY;
      end

      S_DELRD: begin
        row_we   = 1'b1;
        count_d  = count_q - ID_W'(1);
        rep_id_d = rid_q;
        state_d  = S_REPLY;
      end

      S_SCAN: begin
        // Hold while a new hit would displace a held match that cannot
        // yet go out; the memory output stays put as no read is issued.
        if (!(scan_hit && pend_v_q && out_busy)) begin
          if (scan_hit) begin
            if (pend_v_q) begin
              out_load  = 1'b1;
              emit_row  = pend_id_q;
              emit_last = 1'b0;
            end
            pend_v_d  = 1'b1;
            pend_id_d = cmp_id_q;
            hit_cnt_d = hit_cnt_q + ID_W'(1);
          end
          if (issue) begin
            mem_re     = 1'b1;
            mem_raddr  = to_addr(scan_idx_q);
            scan_idx_d = scan_idx_q + ID_W'(1);
            cmp_v_d    = 1'b1;
            cmp_id_d   = scan_idx_q + ID_W'(1);
          end else begin
            cmp_v_d = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!out_busy) begin
          out_load = 1'b1;
          emit_row = pend_v_q ? pend_id_q : '0;
          state_d  = S_IDLE;
        end
      end

      S_REPLY: begin
        if (!out_busy) begin
          out_load    = 1'b1;
          emit_status = rep_status_q;
          emit_row    = rep_id_q;
          emit_data   = rep_data_q;
          emit_hash   = rep_hash_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      hit_cnt_q   <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cmp_v_q    <= cmp_v_d;
      pend_v_q   <= pend_v_d;
      hit_cnt_q  <= hit_cnt_d;
      scan_idx_q <= scan_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    rid_q        <= rid_d;
    key_q        <= key_d;
    wr_addr_q    <= wr_addr_d;
    wr_row_q     <= wr_row_d;
    rep_status_q <= rep_status_d;
    rep_id_q     <= rep_id_d;
    rep_data_q   <= rep_data_d;
    rep_hash_q   <= rep_hash_d;
    cmp_id_q     <= cmp_id_d;
    pend_id_q    <= pend_id_d;
    if (out_load) begin
      out_status_q <= emit_status;
      out_row_q    <= emit_row;
      out_data_q   <= emit_data;
      out_hash_q   <= emit_hash;
      out_held_q   <= count_d;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign result_row_o = out_row_q;
  assign read_data_o  = out_data_q;
  assign read_hash_o  = out_hash_q;
  assign rows_held_o  = out_held_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ID_W'(CAP_TOP))
    else $error("row count beyond the table depth");

  a_idle_hash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hash_sts.busy)
    else $error("request taken while the hash unit is busy");

  a_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> ((state_q == S_HASH) || (state_q == S_DELRD)))
    else $error("memory write outside a write state");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

  a_scan_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (hit_cnt_q < limit))
    else $error("scan continued past the match limit");
`endif

endmodule

### hw/rtl/rss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rss_hash.sv
// Iterative FNV-1a hash over a four-byte window, one byte per cycle.
// Depends on rss_pkg for the hash constants and the status struct.
module rss_hash import rss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              enable_i,
  input  logic [HASH_W-1:0] window_i,
  output hash_sts_t         sts_o,
  output logic [HASH_W-1:0] hash_o
);

  localparam int STEP_W = $clog2(HASH_SPAN);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [HASH_W-1:0] h_q, h_d;
  logic [HASH_W-1:0] win_q, win_d;
  logic [7:0]        cur_byte;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] shifted;

  assign shifted  = win_q >> {step_q, 3'b000};
  assign cur_byte = shifted[7:0];
  assign mixed    = h_q ^ {{(HASH_W-8){1'b0}}, cur_byte};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    h_d    = h_q;
    win_d  = win_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      h_d    = FNV_BASIS;
      win_d  = window_i;
    end else if (busy_q) begin
      h_d    = mixed * FNV_PRIME;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(HASH_SPAN - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    win_q <= win_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign hash_o     = enable_i ? h_q : '0;

endmodule

### hw/rtl/rss_cfg.sv
// APB-style configuration register file of the row store.
// Depends on rss_pkg for register indexes and the configuration struct.
module rss_cfg import rss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROW_BYTES:    cfg_d.row_bytes    = pwdata[3:0];
        REG_CAPACITY:     cfg_d.capacity     = pwdata[6:0];
        REG_KEY_OFFSET:   cfg_d.key_offset   = pwdata[2:0];
        REG_KEY_BYTES:    cfg_d.key_bytes    = pwdata[3:0];
        REG_INDEX_ENABLE: cfg_d.index_enable = pwdata[0];
        REG_INDEX_OFFSET: cfg_d.index_offset = pwdata[2:0];
        REG_MAX_MATCHES:  cfg_d.max_matches  = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_BYTES:    prdata = APB_W'(cfg_q.row_bytes);
      REG_CAPACITY:     prdata = APB_W'(cfg_q.capacity);
      REG_KEY_OFFSET:   prdata = APB_W'(cfg_q.key_offset);
      REG_KEY_BYTES:    prdata = APB_W'(cfg_q.key_bytes);
      REG_INDEX_ENABLE: prdata = APB_W'(cfg_q.index_enable);
      REG_INDEX_OFFSET: prdata = APB_W'(cfg_q.index_offset);
      REG_MAX_MATCHES:  prdata = APB_W'(cfg_q.max_matches);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_bytes    <= 4'd8;
      cfg_q.capacity     <= 7'd64;
      cfg_q.key_offset   <= 3'd0;
      cfg_q.key_bytes    <= 4'd1;
      cfg_q.index_enable <= 1'b0;
      cfg_q.index_offset <= 3'd0;
      cfg_q.max_matches  <= 7'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
